@@ src/dtse_pkg.sv @@
// Package for the date and time setting editor: payload structs, event codes,
// field codes, range limits and the month length function. No dependencies.
`timescale 1ns / 1ps

package dtse_pkg;

    // Event codes carried in the kind field of an input item.
    typedef enum logic [2:0] {
        KIND_MODE = 3'd0,
        KIND_NEXT = 3'd1,
        KIND_INC  = 3'd2,
        KIND_DEC  = 3'd3,
        KIND_LOAD = 3'd4
    } kind_t;

    // Field selection codes.
    typedef enum logic [2:0] {
        FIELD_YEAR   = 3'd0,
        FIELD_MONTH  = 3'd1,
        FIELD_DAY    = 3'd2,
        FIELD_HOUR   = 3'd3,
        FIELD_MINUTE = 3'd4,
        FIELD_SECOND = 3'd5
    } field_t;

    localparam logic [2:0] NUM_FIELDS = 3'd6;

    localparam logic [6:0] YEAR_MAX   = 7'd99;
    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINSEC_MAX = 6'd59;
    localparam logic [4:0] DAYS_LONG  = 5'd31;
    localparam logic [4:0] DAYS_SHORT = 5'd30;
    localparam logic [4:0] DAYS_LEAP  = 5'd29;
    localparam logic [4:0] DAYS_FEB   = 5'd28;
    localparam logic [3:0] MONTH_FEB  = 4'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] new_year;
        logic [3:0] new_month;
        logic [4:0] new_day;
        logic [4:0] new_hour;
        logic [5:0] new_minute;
        logic [5:0] new_second;
    } dtse_in_t;

    typedef struct packed {
        logic       editing;
        logic [2:0] field;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       commit;
    } dtse_out_t;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } dtse_cal_t;

    // Architectural state of the editor.
    typedef struct packed {
        logic       editing;
        logic [2:0] field;
        dtse_cal_t  cal;
    } dtse_state_t;

    // Length of a month; February is a leap month when the year is a multiple of four.
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic [6:0] year);
        logic [4:0] len;
        if (month == MONTH_FEB) begin
            len = (year[1:0] == 2'd0) ? DAYS_LEAP : DAYS_FEB;
        end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = DAYS_SHORT;
        end else begin
            len = DAYS_LONG;
        end
        return len;
    endfunction

endpackage

@@ src/date_time_setting_editor_core.sv @@
// Top level of the date and time setting editor for a six-field calendar clock.
// Depends on dtse_pkg, dtse_in_reg, dtse_update and dtse_out_reg.
//
// Usage:
// Each transfer on the s_ channel carries one key event (mode toggle, next field,
// increment, decrement or a load of fresh clock values). Each event yields exactly
// one transfer on the m_ channel with the editor state after the event: edit flag,
// selected field, the six calendar fields, and a commit flag that is set only on
// the event that leaves edit mode, telling the host to write the time back.
// An event is captured in the input register, applied by a short block of logic
// and stored in the state register, which is also the result register. The result
// is offered on m_valid once the event has passed both registers, and leaves when m_ready is high.
// Throughput is one event per cycle as long as the receiver keeps m_ready high;
// the input register takes a new event in the same cycle as the previous one moves
// on. When the receiver stalls, the current result holds steady, one more event
// waits in the input register, and s_ready then drops until the result is taken.
// Reset (aresetn low at a clock edge) empties both registers and puts the editor
// in show mode with year 0, month 1, day 1 and zero time, year field selected.
`timescale 1ns / 1ps

module date_time_setting_editor_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dtse_pkg::dtse_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output dtse_pkg::dtse_out_t m_payload
);
    import dtse_pkg::*;

    logic        item_valid;
    dtse_in_t    item;
    logic        out_free;
    logic        advance;
    dtse_state_t cur_state;
    dtse_state_t nxt_state;
    logic        commit;

    // An event moves into the state register when one is waiting and the
    // previous result has been taken or is being taken in this cycle.
    assign advance = item_valid && out_free;

    dtse_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dtse_update u_update (
        .item   (item),
        .cur    (cur_state),
        .nxt    (nxt_state),
        .commit (commit)
    );

    dtse_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .nxt       (nxt_state),
        .commit    (commit),
        .free      (out_free),
        .cur       (cur_state),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

@@ src/dtse_in_reg.sv @@
// Input register of the date and time setting editor.
// Depends on dtse_pkg for the input payload struct.
`timescale 1ns / 1ps

module dtse_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dtse_pkg::dtse_in_t s_payload,
    input  logic              advance,
    output logic              item_valid,
    output dtse_pkg::dtse_in_t item
);
    import dtse_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    dtse_in_t item_reg;

    // The register may take a new item when it is empty or drains this cycle.
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_payload;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ src/dtse_update.sv @@
// Next-state logic of the date and time setting editor: applies one event.
// Depends on dtse_pkg for payload and state structs, codes and limits.
`timescale 1ns / 1ps

module dtse_update (
    input  dtse_pkg::dtse_in_t    item,
    input  dtse_pkg::dtse_state_t cur,
    output dtse_pkg::dtse_state_t nxt,
    output logic                  commit
);
    import dtse_pkg::*;

    logic [2:0] sel;
    logic [4:0] cur_len;
    logic [4:0] nxt_len;
    dtse_state_t upd;

    always_comb begin
        upd     = cur;
        commit  = 1'b0;
        sel     = (cur.field >= NUM_FIELDS) ? cur.field - NUM_FIELDS : cur.field;
        cur_len = month_len(cur.cal.month, cur.cal.year);

        case (item.kind)
            KIND_MODE: begin
                if (!cur.editing) begin
                    upd.editing = 1'b1;
                    upd.field   = FIELD_YEAR;
                end else begin
                    upd.editing = 1'b0;
                    commit      = 1'b1;
                end
            end
            KIND_NEXT: begin
                if (cur.editing) begin
                    upd.field = (sel == FIELD_SECOND) ? FIELD_YEAR : sel + 3'd1;
                end
            end
            KIND_INC: begin
                if (cur.editing) begin
                    case (sel)
                        FIELD_YEAR: begin
                            upd.cal.year = (cur.cal.year >= YEAR_MAX) ? 7'd0
                                                                      : cur.cal.year + 7'd1;
                        end
                        FIELD_MONTH: begin
                            upd.cal.month = (cur.cal.month >= MONTH_MAX) ? 4'd1
                                                                         : cur.cal.month + 4'd1;
                        end
                        FIELD_DAY: begin
                            upd.cal.day = (cur.cal.day >= cur_len) ? 5'd1 : cur.cal.day + 5'd1;
                        end
                        FIELD_HOUR: begin
                            upd.cal.hour = (cur.cal.hour >= HOUR_MAX) ? 5'd0
                                                                      : cur.cal.hour + 5'd1;
                        end
                        FIELD_MINUTE: begin
                            upd.cal.minute = (cur.cal.minute >= MINSEC_MAX) ? 6'd0
                                                                            : cur.cal.minute + 6'd1;
                        end
                        default: begin
                            upd.cal.second = (cur.cal.second >= MINSEC_MAX) ? 6'd0
                                                                            : cur.cal.second + 6'd1;
                        end
                    endcase
                end
            end
            KIND_DEC: begin
                if (cur.editing) begin
                    case (sel)
                        FIELD_YEAR: begin
                            upd.cal.year = (cur.cal.year == 7'd0) ? YEAR_MAX
                                                                  : cur.cal.year - 7'd1;
                        end
                        FIELD_MONTH: begin
                            upd.cal.month = (cur.cal.month <= 4'd1) ? MONTH_MAX
                                                                    : cur.cal.month - 4'd1;
                        end
                        FIELD_DAY: begin
                            upd.cal.day = (cur.cal.day <= 5'd1) ? cur_len : cur.cal.day - 5'd1;
                        end
                        FIELD_HOUR: begin
                            upd.cal.hour = (cur.cal.hour == 5'd0) ? HOUR_MAX
                                                                  : cur.cal.hour - 5'd1;
                        end
                        FIELD_MINUTE: begin
                            upd.cal.minute = (cur.cal.minute == 6'd0) ? MINSEC_MAX
                                                                      : cur.cal.minute - 6'd1;
                        end
                        default: begin
                            upd.cal.second = (cur.cal.second == 6'd0) ? MINSEC_MAX
                                                                      : cur.cal.second - 6'd1;
                        end
                    endcase
                end
            end
            KIND_LOAD: begin
                if (!cur.editing) begin
                    upd.cal.year   = (item.new_year > YEAR_MAX) ? 7'd0 : item.new_year;
                    upd.cal.month  = (item.new_month == 4'd0 || item.new_month > MONTH_MAX)
                                     ? 4'd1 : item.new_month;
                    upd.cal.day    = (item.new_day == 5'd0) ? 5'd1 : item.new_day;
                    upd.cal.hour   = (item.new_hour > HOUR_MAX) ? 5'd0 : item.new_hour;
                    upd.cal.minute = (item.new_minute > MINSEC_MAX) ? 6'd0 : item.new_minute;
                    upd.cal.second = (item.new_second > MINSEC_MAX) ? 6'd0 : item.new_second;
                end
            end
            default: begin
            end
        endcase

        // Pull the day back to the first when it no longer fits its month.
        nxt     = upd;
        nxt_len = month_len(upd.cal.month, upd.cal.year);
        if (upd.cal.day > nxt_len) begin
            nxt.cal.day = 5'd1;
        end
    end

endmodule

@@ src/dtse_out_reg.sv @@
// State and result register of the date and time setting editor.
// Depends on dtse_pkg for state and result structs and field codes.
`timescale 1ns / 1ps

module dtse_out_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  dtse_pkg::dtse_state_t nxt,
    input  logic                  commit,
    output logic                  free,
    output dtse_pkg::dtse_state_t cur,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dtse_pkg::dtse_out_t   m_payload
);
    import dtse_pkg::*;

    dtse_state_t state_reg;
    logic        commit_reg;
    logic        valid_reg;
    logic        valid_next;

    // The shown result always equals the state, so the state register doubles as
    // the result register; it only changes once the previous result has gone.
    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg          <= 1'b0;
            commit_reg         <= 1'b0;
            state_reg.editing  <= 1'b0;
            state_reg.field    <= FIELD_YEAR;
            state_reg.cal      <= '{year: 7'd0, month: 4'd1, day: 5'd1,
                                    hour: 5'd0, minute: 6'd0, second: 6'd0};
        end else begin
            valid_reg <= valid_next;
            if (load) begin
                state_reg  <= nxt;
                commit_reg <= commit;
            end
        end
    end

    assign cur     = state_reg;
    assign m_valid = valid_reg;

    always_comb begin
        m_payload.editing = state_reg.editing;
        m_payload.field   = state_reg.field;
        m_payload.year    = state_reg.cal.year;
        m_payload.month   = state_reg.cal.month;
        m_payload.day     = state_reg.cal.day;
        m_payload.hour    = state_reg.cal.hour;
        m_payload.minute  = state_reg.cal.minute;
        m_payload.second  = state_reg.cal.second;
        m_payload.commit  = commit_reg;
    end

endmodule

@@ src/dtse_checker.sv @@
// Port-level checks for the date and time setting editor, bound to its top level.
// Depends on dtse_pkg and date_time_setting_editor_core.
`timescale 1ns / 1ps

module dtse_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input dtse_pkg::dtse_out_t m_payload
);
    import dtse_pkg::*;

    // A stalled result stays offered and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // Nothing is offered right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered after reset");

    // Commit only comes with the return to show mode.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.commit |-> !m_payload.editing)
        else $error("commit while still editing");

    // Month and field stay within their ranges, and the day is never zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.month >= 4'd1 && m_payload.month <= MONTH_MAX &&
                    m_payload.day >= 5'd1 && m_payload.field < NUM_FIELDS)
        else $error("calendar field out of range");

    // The day never exceeds the length of February.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.month == MONTH_FEB |->
            (m_payload.year[1:0] == 2'd0) ? (m_payload.day <= DAYS_LEAP)
                                          : (m_payload.day <= DAYS_FEB))
        else $error("day beyond end of February");

endmodule

bind date_time_setting_editor_core dtse_checker u_dtse_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
